[hdl/plro_pkg.sv]
// ============================================================================
// plro_pkg
// Types, widths and helpers shared by the polyline ribbon offset block.
// ============================================================================
`default_nettype none

package plro_pkg;

	// Field widths
	localparam int COORD_BITS  = 32;
	localparam int NORMAL_BITS = 16;
	localparam int WIDTH_BITS  = 31;

	// Segment difference and its magnitude register
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int MD_BITS   = (DIFF_BITS > 33) ? DIFF_BITS : 33;

	// Cross product: signed normal times a 33-bit signed segment component
	localparam int PROD_BITS  = NORMAL_BITS + 33;
	localparam int CROSS_BITS = NORMAL_BITS + 34;
	localparam int MC_BITS    = CROSS_BITS - 1;

	// Signed offset (magnitude below 2^32)
	localparam int OFF_BITS = 33;

	// Position plus offset before saturation
	localparam int SUM_BITS = ((COORD_BITS > OFF_BITS) ? COORD_BITS : OFF_BITS) + 1;
	localparam logic signed [SUM_BITS-1:0] SAT_HI =
		SUM_BITS'({1'b0, {(COORD_BITS-1){1'b1}}});
	localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

	// Side codes
	localparam logic [1:0] SIDE_LEFT   = 2'd0;
	localparam logic [1:0] SIDE_CENTRE = 2'd1;
	localparam logic [1:0] SIDE_RIGHT  = 2'd2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0]  pos_x;
		logic signed [COORD_BITS-1:0]  pos_y;
		logic signed [COORD_BITS-1:0]  pos_z;
		logic signed [NORMAL_BITS-1:0] norm_x;
		logic signed [NORMAL_BITS-1:0] norm_y;
		logic signed [NORMAL_BITS-1:0] norm_z;
		logic [WIDTH_BITS-1:0]         ribbon_width;
		logic                          curve_end;
	} point_t;

	typedef struct packed {
		logic [1:0]                   side;
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic signed [COORD_BITS-1:0] out_z;
		logic                         curve_done;
		logic                         last;
	} vertex_t;

	// Clamp a widened coordinate to the signed coordinate range
	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [SUM_BITS-1:0] v);
		logic signed [COORD_BITS-1:0] r;
		if (v > SAT_HI)
			r = SAT_HI[COORD_BITS-1:0];
		else if (v < SAT_LO)
			r = SAT_LO[COORD_BITS-1:0];
		else
			r = v[COORD_BITS-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/plro_offset.sv]
// ============================================================================
// plro_offset
// Sequential offset unit: normal x segment, normalized, scaled by half width.
// Shared cross-product multiplier, bit-serial square root and bit-serial divider.
// ============================================================================
`default_nettype none

module plro_offset (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic signed [plro_pkg::NORMAL_BITS-1:0] norm [3],
	input  wire logic signed [plro_pkg::DIFF_BITS-1:0]   diff [3],
	input  wire logic [plro_pkg::WIDTH_BITS-1:0]         width,
	output logic done,
	output logic signed [plro_pkg::OFF_BITS-1:0] off [3]
);

	localparam logic [3:0] U_IDLE  = 4'd0;
	localparam logic [3:0] U_DNORM = 4'd1;
	localparam logic [3:0] U_CROSS = 4'd2;
	localparam logic [3:0] U_CMAG  = 4'd3;
	localparam logic [3:0] U_CNORM = 4'd4;
	localparam logic [3:0] U_SQ    = 4'd5;
	localparam logic [3:0] U_ROOT  = 4'd6;
	localparam logic [3:0] U_DIV   = 4'd7;
	localparam logic [3:0] U_SCALE = 4'd8;
	localparam logic [3:0] U_DONE  = 4'd9;

	localparam int DVD_BITS = 61;

	logic [3:0] state_q;
	logic [2:0] step_q;
	logic [1:0] comp_q;
	logic [5:0] cnt_q;

	logic signed [plro_pkg::NORMAL_BITS-1:0] n_q [3];
	logic [plro_pkg::WIDTH_BITS-1:0]         w_q;
	logic                                    sgn_d_q [3];
	logic [plro_pkg::MD_BITS-1:0]            md_q [3];
	logic signed [plro_pkg::CROSS_BITS-1:0]  c_q [3];
	logic                                    sgn_c_q [3];
	logic [plro_pkg::MC_BITS-1:0]            mc_q [3];
	logic [63:0] sum_q, rv_q, root_q, bit_q;
	logic [DVD_BITS-1:0] dvd_q;
	logic [31:0] rem_q, quo_q;
	logic signed [plro_pkg::OFF_BITS-1:0] off_q [3];

	// Cross product schedule: operand selection per step
	logic signed [plro_pkg::NORMAL_BITS-1:0] mul_n;
	logic [1:0] dsel;
	logic       sub;
	logic [31:0] dmag;
	logic signed [32:0] dv;
	logic signed [plro_pkg::PROD_BITS-1:0] prod;
	logic signed [plro_pkg::CROSS_BITS-1:0] addend;
	logic [1:0] tgt;

	always_comb begin
		case (step_q)
			3'd0: begin mul_n = n_q[1]; dsel = 2'd2; sub = 1'b0; end
			3'd1: begin mul_n = n_q[2]; dsel = 2'd1; sub = 1'b1; end
			3'd2: begin mul_n = n_q[2]; dsel = 2'd0; sub = 1'b0; end
			3'd3: begin mul_n = n_q[0]; dsel = 2'd2; sub = 1'b1; end
			3'd4: begin mul_n = n_q[0]; dsel = 2'd1; sub = 1'b0; end
			3'd5: begin mul_n = n_q[1]; dsel = 2'd0; sub = 1'b1; end
			default: begin mul_n = n_q[0]; dsel = 2'd0; sub = 1'b0; end
		endcase
		tgt    = step_q[2:1];
		dmag   = md_q[dsel][31:0];
		dv     = sgn_d_q[dsel] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
		prod   = mul_n * dv;
		addend = sub ? -plro_pkg::CROSS_BITS'(prod) : plro_pkg::CROSS_BITS'(prod);
	end

	// Normalization tests
	logic d_big, c_hi, c_b30, c_zero;
	always_comb begin
		d_big  = 1'b0;
		c_hi   = 1'b0;
		c_b30  = 1'b0;
		c_zero = 1'b1;
		for (int i = 0; i < 3; i++) begin
			d_big  = d_big | (|md_q[i][plro_pkg::MD_BITS-1:32]);
			c_hi   = c_hi | (|mc_q[i][plro_pkg::MC_BITS-1:31]);
			c_b30  = c_b30 | mc_q[i][30];
			c_zero = c_zero & (c_q[i] == '0);
		end
	end

	// Square, root step, divide step, scale
	logic [30:0] sq_in;
	logic [61:0] sq;
	logic [63:0] trial_r;
	logic [32:0] trial_d;
	logic [61:0] wu;
	logic [62:0] wr;
	logic [31:0] om;
	always_comb begin
		sq_in   = mc_q[comp_q][30:0];
		sq      = sq_in * sq_in;
		trial_r = root_q + bit_q;
		trial_d = {rem_q, dvd_q[DVD_BITS-1]};
		wu      = w_q * quo_q[30:0];
		wr      = {1'b0, wu} + 63'(64'd1 << 30);
		om      = wr[62:31];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			step_q  <= '0;
			comp_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				U_IDLE: begin
					if (start)
						state_q <= U_DNORM;
				end
				U_DNORM: begin
					if (!d_big) begin
						state_q <= U_CROSS;
						step_q  <= '0;
					end
				end
				U_CROSS: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd5)
						state_q <= U_CMAG;
				end
				U_CMAG: begin
					state_q <= c_zero ? U_DONE : U_CNORM;
				end
				U_CNORM: begin
					if (!c_hi && c_b30) begin
						state_q <= U_SQ;
						comp_q  <= '0;
					end
				end
				U_SQ: begin
					comp_q <= comp_q + 2'd1;
					if (comp_q == 2'd2)
						state_q <= U_ROOT;
				end
				U_ROOT: begin
					if (bit_q[0]) begin
						state_q <= U_DIV;
						comp_q  <= '0;
						cnt_q   <= '0;
					end
				end
				U_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DVD_BITS - 1))
						state_q <= U_SCALE;
				end
				U_SCALE: begin
					cnt_q <= '0;
					if (comp_q == 2'd2) begin
						state_q <= U_DONE;
					end else begin
						comp_q  <= comp_q + 2'd1;
						state_q <= U_DIV;
					end
				end
				U_DONE: begin
					state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (start) begin
					w_q <= width;
					for (int i = 0; i < 3; i++) begin
						n_q[i]     <= norm[i];
						sgn_d_q[i] <= diff[i][plro_pkg::DIFF_BITS-1];
						md_q[i]    <= plro_pkg::MD_BITS'($unsigned(
							diff[i][plro_pkg::DIFF_BITS-1] ? -diff[i] : diff[i]));
						c_q[i]     <= '0;
					end
				end
			end
			U_DNORM: begin
				if (d_big)
					for (int i = 0; i < 3; i++)
						md_q[i] <= md_q[i] >> 1;
			end
			U_CROSS: begin
				c_q[tgt] <= c_q[tgt] + addend;
			end
			U_CMAG: begin
				for (int i = 0; i < 3; i++) begin
					sgn_c_q[i] <= c_q[i][plro_pkg::CROSS_BITS-1];
					mc_q[i]    <= plro_pkg::MC_BITS'($unsigned(
						c_q[i][plro_pkg::CROSS_BITS-1] ? -c_q[i] : c_q[i]));
					if (c_zero)
						off_q[i] <= '0;
				end
				sum_q <= '0;
			end
			U_CNORM: begin
				for (int i = 0; i < 3; i++) begin
					if (c_hi)
						mc_q[i] <= mc_q[i] >> 1;
					else if (!c_b30)
						mc_q[i] <= mc_q[i] << 1;
				end
			end
			U_SQ: begin
				sum_q <= sum_q + 64'(sq);
				if (comp_q == 2'd2) begin
					rv_q   <= sum_q + 64'(sq);
					root_q <= '0;
					bit_q  <= 64'd1 << 62;
				end
			end
			U_ROOT: begin
				if (rv_q >= trial_r) begin
					rv_q   <= rv_q - trial_r;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					dvd_q <= {mc_q[0][30:0], 30'd0};
					rem_q <= '0;
					quo_q <= '0;
				end
			end
			U_DIV: begin
				if (trial_d >= {1'b0, root_q[31:0]}) begin
					rem_q <= 32'(trial_d - {1'b0, root_q[31:0]});
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= trial_d[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
				dvd_q <= dvd_q << 1;
			end
			U_SCALE: begin
				off_q[comp_q] <= sgn_c_q[comp_q] ? -$signed({1'b0, om}) : $signed({1'b0, om});
				if (comp_q != 2'd2) begin
					dvd_q <= {mc_q[comp_q + 2'd1][30:0], 30'd0};
					rem_q <= '0;
					quo_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign done = (state_q == U_DONE);
	assign off  = off_q;

endmodule

`default_nettype wire

[hdl/polyline_ribbon_offset.sv]
// ============================================================================
// polyline_ribbon_offset
// Turns a stream of curve points into left, centre and right ribbon vertices.
// ============================================================================
// Each point is held until its successor arrives; the successor's segment
// sets the held point's offset direction, and a curve's final point uses the
// segment before it. A point that opens a curve gives no beat. Each offset
// direction is computed in the offset unit by one-bit-per-cycle normalizing
// shifts, six cross-product multiplies, a 32-step bit-serial square root and
// three 61-step bit-serial divisions; a zero cross product gives a zero offset
// and skips the rest. Every emitted triple then takes 3 output beats; a final
// point after a held one needs two offset computations and gives 6 beats.
`default_nettype none

module polyline_ribbon_offset (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic point_valid,
	output logic point_ready,
	input  wire plro_pkg::point_t point,
	output logic vertex_valid,
	input  wire logic vertex_ready,
	output plro_pkg::vertex_t vertex
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_WAIT1  = 3'd2;
	localparam logic [2:0] S_EMIT1  = 3'd3;
	localparam logic [2:0] S_WAIT2  = 3'd4;
	localparam logic [2:0] S_EMIT2  = 3'd5;

	logic [2:0] state_q;
	logic [1:0] side_q;
	logic       zero_off_q;

	logic signed [plro_pkg::COORD_BITS-1:0]  cur_pos_q [3];
	logic signed [plro_pkg::NORMAL_BITS-1:0] cur_norm_q [3];
	logic [plro_pkg::WIDTH_BITS-1:0]         cur_w_q;
	logic                                    cur_end_q;
	logic signed [plro_pkg::COORD_BITS-1:0]  held_pos_q [3];
	logic signed [plro_pkg::NORMAL_BITS-1:0] held_norm_q [3];
	logic [plro_pkg::WIDTH_BITS-1:0]         held_w_q;
	logic                                    held_valid_q;

	logic            vout_q;
	plro_pkg::vertex_t vertex_q;

	// Offset unit operands
	logic signed [plro_pkg::DIFF_BITS-1:0]   diff [3];
	logic signed [plro_pkg::NORMAL_BITS-1:0] u_norm [3];
	logic [plro_pkg::WIDTH_BITS-1:0]         u_width;
	logic signed [plro_pkg::OFF_BITS-1:0]    u_off [3];
	logic u_start, u_done;

	// The final point's own offset is started from EMIT1; every other start
	// works on the held point
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i]   = plro_pkg::DIFF_BITS'(cur_pos_q[i]) - plro_pkg::DIFF_BITS'(held_pos_q[i]);
			u_norm[i] = (state_q == S_EMIT1) ? cur_norm_q[i] : held_norm_q[i];
		end
		u_width = (state_q == S_EMIT1) ? cur_w_q : held_w_q;
	end

	plro_offset u_offset (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (u_start),
		.norm   (u_norm),
		.diff   (diff),
		.width  (u_width),
		.done   (u_done),
		.off    (u_off)
	);

	// Beat formation
	logic emitting, load, tri_end, is_right;
	logic signed [plro_pkg::COORD_BITS-1:0] base [3];
	logic signed [plro_pkg::OFF_BITS-1:0]   offs [3];
	logic signed [plro_pkg::COORD_BITS-1:0] coord [3];
	logic signed [plro_pkg::SUM_BITS-1:0]   sum [3];
	plro_pkg::vertex_t beat;

	always_comb begin
		emitting = (state_q == S_EMIT1) || (state_q == S_EMIT2);
		load     = emitting && (!vout_q || vertex_ready);
		is_right = (side_q == plro_pkg::SIDE_RIGHT);
		tri_end  = load && is_right;
		for (int i = 0; i < 3; i++) begin
			base[i] = (state_q == S_EMIT1) ? held_pos_q[i] : cur_pos_q[i];
			offs[i] = zero_off_q ? '0 : u_off[i];
			case (side_q)
				plro_pkg::SIDE_LEFT:
					sum[i] = plro_pkg::SUM_BITS'(base[i]) - plro_pkg::SUM_BITS'(offs[i]);
				plro_pkg::SIDE_RIGHT:
					sum[i] = plro_pkg::SUM_BITS'(base[i]) + plro_pkg::SUM_BITS'(offs[i]);
				default:
					sum[i] = plro_pkg::SUM_BITS'(base[i]);
			endcase
			coord[i] = plro_pkg::sat_coord(sum[i]);
		end
		beat.side       = side_q;
		beat.out_x      = coord[0];
		beat.out_y      = coord[1];
		beat.out_z      = coord[2];
		beat.curve_done = (state_q == S_EMIT2) && is_right;
		beat.last       = is_right && ((state_q == S_EMIT2) || !cur_end_q);
	end

	assign u_start = ((state_q == S_DECIDE) && held_valid_q)
		|| ((state_q == S_EMIT1) && tri_end && cur_end_q);

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			side_q       <= plro_pkg::SIDE_LEFT;
			zero_off_q   <= 1'b0;
			held_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (point_valid)
						state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					side_q <= plro_pkg::SIDE_LEFT;
					if (held_valid_q) begin
						zero_off_q <= 1'b0;
						state_q    <= S_WAIT1;
					end else if (cur_end_q) begin
						zero_off_q <= 1'b1;
						state_q    <= S_EMIT2;
					end else begin
						zero_off_q   <= 1'b0;
						held_valid_q <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_WAIT1: begin
					if (u_done)
						state_q <= S_EMIT1;
				end
				S_EMIT1: begin
					if (tri_end) begin
						side_q <= plro_pkg::SIDE_LEFT;
						if (cur_end_q)
							state_q <= S_WAIT2;
						else
							state_q <= S_IDLE;
					end else if (load) begin
						side_q <= side_q + 2'd1;
					end
				end
				S_WAIT2: begin
					if (u_done)
						state_q <= S_EMIT2;
				end
				S_EMIT2: begin
					if (tri_end) begin
						side_q       <= plro_pkg::SIDE_LEFT;
						held_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end else if (load) begin
						side_q <= side_q + 2'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Current and held point payload
	always_ff @(posedge clk) begin
		if (point_valid && point_ready) begin
			cur_pos_q[0]  <= point.pos_x;
			cur_pos_q[1]  <= point.pos_y;
			cur_pos_q[2]  <= point.pos_z;
			cur_norm_q[0] <= point.norm_x;
			cur_norm_q[1] <= point.norm_y;
			cur_norm_q[2] <= point.norm_z;
			cur_w_q       <= point.ribbon_width;
			cur_end_q     <= point.curve_end;
		end
		if (((state_q == S_DECIDE) && !held_valid_q && !cur_end_q)
			|| ((state_q == S_EMIT1) && tri_end && !cur_end_q)) begin
			held_pos_q  <= cur_pos_q;
			held_norm_q <= cur_norm_q;
			held_w_q    <= cur_w_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vout_q <= 1'b0;
		else if (load)
			vout_q <= 1'b1;
		else if (vertex_ready)
			vout_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			vertex_q <= beat;
	end

	assign point_ready  = (state_q == S_IDLE);
	assign vertex_valid = vout_q;
	assign vertex       = vertex_q;

	// Checks
	a_done_right: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && vertex.curve_done |-> vertex.last && vertex.side == plro_pkg::SIDE_RIGHT)
		else $error("curve_done beat is not the final right edge");

	a_side_code: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid |-> vertex.side <= plro_pkg::SIDE_RIGHT)
		else $error("vertex side code out of range");

	a_unit_wait: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> state_q == S_WAIT1 || state_q == S_WAIT2)
		else $error("offset unit finished while nobody waits");

endmodule

`default_nettype wire

[sim/polyline_ribbon_offset_tb.sv]
// ============================================================================
// polyline_ribbon_offset_tb
// Self-checking bench: random and directed curve points go in, every
// left/centre/right vertex beat is checked against a behavioral offset model.
// ============================================================================
`timescale 1ns / 1ps

module polyline_ribbon_offset_tb;

	logic              clk;
	logic              arst_n;
	logic              point_valid = 1'b0;
	logic              point_ready;
	plro_pkg::point_t  point = '0;
	logic              vertex_valid;
	logic              vertex_ready = 1'b0;
	plro_pkg::vertex_t vertex;

	polyline_ribbon_offset dut (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_ready(point_ready), .point(point),
		.vertex_valid(vertex_valid), .vertex_ready(vertex_ready), .vertex(vertex)
	);

	// Pending points and the vertices they should produce
	plro_pkg::point_t  pending_pts[$];
	plro_pkg::vertex_t vertex_queue[$];
	int      errors = 0;
	int      n_vertices = 0;
	int      n_points = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	bit      hold_send = 0;
	bit      point_ready_seen = 0;
	longint  cycles = 0;

	// Ribbon model state
	longint mdl_pos[3] = '{0, 0, 0};
	longint mdl_norm[3] = '{0, 0, 0};
	longint unsigned mdl_width = 0;
	bit     mdl_held = 0;

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Half-width offset along the unit of (n x d)
	task automatic ribbon_dir(input longint n[3], input longint d[3],
			input longint unsigned w, output longint off[3]);
		longint unsigned md[3], mc[3], s, r, mx, u, om;
		bit nd[3], nc[3];
		longint dv[3], c[3];
		s = 0;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			nd[i] = d[i] < 0;
			md[i] = nd[i] ? -d[i] : d[i];
			off[i] = 0;
		end
		while (md[0] >= 64'd1 << 32 || md[1] >= 64'd1 << 32 || md[2] >= 64'd1 << 32)
			for (int i = 0; i < 3; i++)
				md[i] >>= 1;
		for (int i = 0; i < 3; i++)
			dv[i] = nd[i] ? -longint'(md[i]) : longint'(md[i]);
		c[0] = n[1] * dv[2] - n[2] * dv[1];
		c[1] = n[2] * dv[0] - n[0] * dv[2];
		c[2] = n[0] * dv[1] - n[1] * dv[0];
		for (int i = 0; i < 3; i++) begin
			nc[i] = c[i] < 0;
			mc[i] = nc[i] ? -c[i] : c[i];
			if (mc[i] > mx)
				mx = mc[i];
		end
		if (mx == 0)
			return;
		while (mx >= 64'd1 << 31) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++)
				mc[i] >>= 1;
		end
		while (mx < 64'd1 << 30) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++)
				mc[i] <<= 1;
		end
		for (int i = 0; i < 3; i++)
			s += mc[i] * mc[i];
		r = root64(s);
		if (r == 0)
			return;
		for (int i = 0; i < 3; i++) begin
			u = (mc[i] << 30) / r;
			om = (w * u + (64'd1 << 30)) >> 31;
			off[i] = nc[i] ? -longint'(om) : longint'(om);
		end
	endtask

	function automatic logic signed [plro_pkg::COORD_BITS-1:0] clamp(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[plro_pkg::COORD_BITS-1:0];
	endfunction

	task automatic push_triple(input longint p[3], input longint off[3], input bit done);
		plro_pkg::vertex_t v;
		longint q[3];
		for (int s = 0; s < 3; s++) begin
			for (int i = 0; i < 3; i++)
				q[i] = (s == 0) ? p[i] - off[i] : (s == 2) ? p[i] + off[i] : p[i];
			v.side = (s == 0) ? plro_pkg::SIDE_LEFT :
				(s == 1) ? plro_pkg::SIDE_CENTRE : plro_pkg::SIDE_RIGHT;
			v.out_x = clamp(q[0]);
			v.out_y = clamp(q[1]);
			v.out_z = clamp(q[2]);
			v.curve_done = (s == 2) && done;
			v.last = 0;
			vertex_queue.insert(vertex_queue.size(), v);
		end
	endtask

	// Predict the vertices released by one accepted point
	task automatic predict_vertices(input plro_pkg::point_t pt);
		longint p[3], n[3], d[3], off[3];
		bit emitted;
		emitted = 0;
		p[0] = pt.pos_x; p[1] = pt.pos_y; p[2] = pt.pos_z;
		n[0] = pt.norm_x; n[1] = pt.norm_y; n[2] = pt.norm_z;
		for (int i = 0; i < 3; i++)
			d[i] = p[i] - mdl_pos[i];
		if (mdl_held) begin
			ribbon_dir(mdl_norm, d, mdl_width, off);
			push_triple(mdl_pos, off, 0);
			emitted = 1;
		end
		if (pt.curve_end) begin
			if (mdl_held)
				ribbon_dir(n, d, pt.ribbon_width, off);
			else
				off = '{0, 0, 0};
			push_triple(p, off, 1);
			emitted = 1;
			mdl_held = 0;
		end else begin
			mdl_pos = p;
			mdl_norm = n;
			mdl_width = pt.ribbon_width;
			mdl_held = 1;
		end
		if (emitted)
			vertex_queue[$].last = 1;
	endtask

	function automatic plro_pkg::point_t make_point(input longint x, input longint y,
			input longint z, input int nx, input int ny, input int nz, input int w,
			input bit e);
		plro_pkg::point_t pt;
		pt.pos_x = plro_pkg::COORD_BITS'(x);
		pt.pos_y = plro_pkg::COORD_BITS'(y);
		pt.pos_z = plro_pkg::COORD_BITS'(z);
		pt.norm_x = plro_pkg::NORMAL_BITS'(nx);
		pt.norm_y = plro_pkg::NORMAL_BITS'(ny);
		pt.norm_z = plro_pkg::NORMAL_BITS'(nz);
		pt.ribbon_width = plro_pkg::WIDTH_BITS'(w);
		pt.curve_end = e;
		return pt;
	endfunction

	function automatic plro_pkg::point_t rand_point(input bit e, input bit wild);
		plro_pkg::point_t pt;
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		pt = raw[$bits(plro_pkg::point_t)-1:0];
		if (!wild) begin
			// modest coordinates and ribbon width; the normal stays random
			pt.pos_x = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
			pt.pos_y = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
			pt.pos_z = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
			pt.ribbon_width = plro_pkg::WIDTH_BITS'($urandom_range(0, 32'h0010_0000));
		end
		pt.curve_end = e;
		return pt;
	endfunction

	function automatic void queue_point(input plro_pkg::point_t pt);
		pending_pts.insert(pending_pts.size(), pt);
	endfunction

	// Clock
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Driver: next pending point is presented at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			// a new beat only once the previous one has been taken
			if (!point_valid || point_ready_seen) begin
				if (pending_pts.size() != 0 && !hold_send &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					point <= pending_pts.pop_front();
					point_valid <= 1;
				end else begin
					point_valid <= 0;
				end
			end
			vertex_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Accepted beats seen at the rising edge
	always @(posedge clk) begin
		cycles <= cycles + 1;
		point_ready_seen <= 0;
		if (arst_n && point_valid && point_ready) begin
			predict_vertices(point);
			n_points <= n_points + 1;
			point_ready_seen <= 1;
		end
		if (arst_n && vertex_valid && vertex_ready) begin
			n_vertices <= n_vertices + 1;
			if (vertex_queue.size() == 0) begin
				$display("%0t: expected no vertex actual %p", $time, vertex);
				errors++;
			end else if (vertex !== vertex_queue[0]) begin
				$display("%0t: expected %p actual %p", $time, vertex_queue[0], vertex);
				errors++;
				void'(vertex_queue.pop_front());
			end else begin
				void'(vertex_queue.pop_front());
			end
		end
		if (cycles > 64'd4_000_000) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_pts.size() != 0 || point_valid || vertex_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_curves(input int n_pts);
		int left;
		int len;
		left = n_pts;
		while (left > 0) begin
			len = $urandom_range(1, 7);
			for (int k = 0; k < len && left > 0; k++, left--)
				queue_point(rand_point(k == len - 1 || left == 1,
					$urandom_range(0, 9) == 0));
		end
	endtask

	// Stimulus
	initial begin
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: single point, zero normal, repeated point, parallel normal,
		// saturating extremes, widest ribbon
		queue_point(make_point(65536, 0, 0, 0, 16384, 0, 65536, 1));
		queue_point(make_point(0, 0, 0, 0, 0, 0, 65536, 0));
		queue_point(make_point(65536, 0, 0, 0, 0, 0, 65536, 1));
		queue_point(make_point(5, 5, 5, 0, 0, 16384, 131072, 0));
		queue_point(make_point(5, 5, 5, 0, 0, 16384, 131072, 1));
		queue_point(make_point(0, 0, 0, 16384, 0, 0, 65536, 0));
		queue_point(make_point(65536, 0, 0, 16384, 0, 0, 65536, 1));
		queue_point(make_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			-32768, 32767, -32768, 31'h7fffffff, 0));
		queue_point(make_point(-64'sd2147483648, -64'sd2147483648, 0,
			32767, -32768, 32767, 31'h7fffffff, 0));
		queue_point(make_point(32'h7fffffff, -64'sd2147483648, 32'h7fffffff,
			0, 16384, 0, 31'h7fffffff, 1));
		queue_point(make_point(0, 0, 0, 0, 16384, 0, 65536, 0));
		queue_point(make_point(65536, 0, 0, 0, 16384, 0, 65536, 0));
		queue_point(make_point(131072, 65536, 0, 0, 16384, 0, 65536, 0));
		queue_point(make_point(196608, 65536, 65536, 0, 0, 16384, 0, 1));
		wait_drained();

		// Sender sparse-idle, receiver heavy stall
		send_idle_pct = 15; recv_idle_pct = 72;
		random_curves(140);
		wait_drained();
		// Hold the sender mid-stream until every released vertex has come back
		random_curves(10);
		while (pending_pts.size() > 5)
			@(posedge clk);
		hold_send = 1;
		while (point_valid || vertex_queue.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		hold_send = 0;
		wait_drained();

		send_idle_pct = 72; recv_idle_pct = 15;
		random_curves(125);
		wait_drained();
		send_idle_pct = 0; recv_idle_pct = 0;
		random_curves(125);
		wait_drained();

		repeat (400) @(posedge clk);
		$display("covered %0d points, %0d vertex beats checked", n_points, n_vertices);
		$display("directed edge cases, both stall mixes, a sender pause and full rate");
		if (errors == 0 && vertex_queue.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

[files.f]
hdl/plro_pkg.sv
hdl/plro_offset.sv
hdl/polyline_ribbon_offset.sv
sim/polyline_ribbon_offset_tb.sv
